/* hw/rtl/ftqg_pkg.sv */
`timescale 1ns / 1ps

package ftqg_pkg;

	// Field and register widths.
	localparam int TIME_W      = 20;
	localparam int DIM_W       = 14;
	localparam int LVL_W       = 2;
	localparam int CHG_W       = 2;
	localparam int ALPHA_W     = 16;
	localparam int ALPHA_FRAC  = 16;
	localparam int ACC_W       = 26;

	// Shared multiplier: a 20 bit operand by a 16 bit operand.
	localparam int MUL_A_W     = 20;
	localparam int MUL_W       = MUL_A_W + ALPHA_W;

	// Cap products fit in 25 bits (16383 * 1280), quotients in DIM_W bits.
	localparam int CAP_PROD_W  = 25;
	localparam int DIV_STEPS   = DIM_W;
	localparam int DIV_CNT_W   = 4;

	// APB register file.
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;
	localparam int REG_IDX_LSB = 2;
	localparam int REG_IDX_W   = PADDR_W - REG_IDX_LSB;

	localparam logic [REG_IDX_W-1:0] REG_ALPHA     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BUDGET    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_UPGRADE   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DOWN_HOLD = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_UP_HOLD   = 3'd4;

	localparam logic [ALPHA_W-1:0] RST_ALPHA     = 16'd3277;
	localparam logic [TIME_W-1:0]  RST_BUDGET    = 20'd20000;
	localparam logic [TIME_W-1:0]  RST_UPGRADE   = 20'd14000;
	localparam logic [ACC_W-1:0]   RST_DOWN_HOLD = 26'd3000000;
	localparam logic [ACC_W-1:0]   RST_UP_HOLD   = 26'd20000000;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

	// Smallest size a cap may produce.
	localparam logic [DIM_W-1:0] MIN_W = 14'd160;
	localparam logic [DIM_W-1:0] MIN_H = 14'd90;

	// Level change codes.
	typedef enum logic [CHG_W-1:0] {
		CHG_NONE    = 2'd0,
		CHG_RAISED  = 2'd1,
		CHG_LOWERED = 2'd2
	} chg_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		logic [TIME_W-1:0]  budget;
		logic [TIME_W-1:0]  upgrade;
		logic [ACC_W-1:0]   down_hold;
		logic [ACC_W-1:0]   up_hold;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic seed;
		logic diff;
		logic mul_lo;
		logic mul_hi;
		logic sum;
		logic avg;
		logic acc;
		logic lvl;
		logic cap_ma;
		logic cap_mb;
		logic cap_sel;
		logic div_step;
		logic cap_fix;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_cap;
		logic t_zero;
		logic avg_valid;
		logic cap_pass;
		logic div_last;
	} dp_sts_t;

	// Box width for levels 1 to 3; level 3 and level 0 (the default) use the smallest box.
	function automatic logic [DIM_W-1:0] box_w(input logic [LVL_W-1:0] lvl);
		logic [DIM_W-1:0] r;
		case (lvl)
			2'd1:    r = 14'd1280;
			2'd2:    r = 14'd960;
			default: r = 14'd640;
		endcase
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] box_h(input logic [LVL_W-1:0] lvl);
		logic [DIM_W-1:0] r;
		case (lvl)
			2'd1:    r = 14'd720;
			2'd2:    r = 14'd540;
			default: r = 14'd360;
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/ftqg_req_if.sv */
`timescale 1ns / 1ps

interface ftqg_req_if;
	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic [ftqg_pkg::TIME_W-1:0]    frame_time_us;
	logic [ftqg_pkg::DIM_W-1:0]     req_width;
	logic [ftqg_pkg::DIM_W-1:0]     req_height;

	modport source (output valid, output req_type, output frame_time_us,
		output req_width, output req_height, input ready);
	modport sink (input valid, input req_type, input frame_time_us,
		input req_width, input req_height, output ready);
endinterface

/* hw/rtl/ftqg_res_if.sv */
`timescale 1ns / 1ps

interface ftqg_res_if;
	logic                           valid;
	logic                           ready;
	logic [ftqg_pkg::LVL_W-1:0]     quality_level;
	logic [ftqg_pkg::CHG_W-1:0]     level_change;
	logic [ftqg_pkg::DIM_W-1:0]     out_width;
	logic [ftqg_pkg::DIM_W-1:0]     out_height;

	modport source (output valid, output quality_level, output level_change,
		output out_width, output out_height, input ready);
	modport sink (input valid, input quality_level, input level_change,
		input out_width, input out_height, output ready);
endinterface

/* hw/rtl/ftqg_cfg.sv */
`timescale 1ns / 1ps

module ftqg_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ftqg_pkg::PADDR_W-1:0]   paddr,
	input  logic [ftqg_pkg::PDATA_W-1:0]   pwdata,
	output logic [ftqg_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output ftqg_pkg::cfg_t                 cfg
);

	logic                               wr_en;
	logic [ftqg_pkg::REG_IDX_W-1:0]     idx;
	ftqg_pkg::cfg_t                     cfg_q;

	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ftqg_pkg::PADDR_W-1:ftqg_pkg::REG_IDX_LSB];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha     <= ftqg_pkg::RST_ALPHA;
			cfg_q.budget    <= ftqg_pkg::RST_BUDGET;
			cfg_q.upgrade   <= ftqg_pkg::RST_UPGRADE;
			cfg_q.down_hold <= ftqg_pkg::RST_DOWN_HOLD;
			cfg_q.up_hold   <= ftqg_pkg::RST_UP_HOLD;
		end else if (wr_en) begin
			case (idx)
				ftqg_pkg::REG_ALPHA:     cfg_q.alpha     <= pwdata[ftqg_pkg::ALPHA_W-1:0];
				ftqg_pkg::REG_BUDGET:    cfg_q.budget    <= pwdata[ftqg_pkg::TIME_W-1:0];
				ftqg_pkg::REG_UPGRADE:   cfg_q.upgrade   <= pwdata[ftqg_pkg::TIME_W-1:0];
				ftqg_pkg::REG_DOWN_HOLD: cfg_q.down_hold <= pwdata[ftqg_pkg::ACC_W-1:0];
				ftqg_pkg::REG_UP_HOLD:   cfg_q.up_hold   <= pwdata[ftqg_pkg::ACC_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back, zero extended.
	always_comb begin
		case (idx)
			ftqg_pkg::REG_ALPHA:     prdata = ftqg_pkg::PDATA_W'(cfg_q.alpha);
			ftqg_pkg::REG_BUDGET:    prdata = ftqg_pkg::PDATA_W'(cfg_q.budget);
			ftqg_pkg::REG_UPGRADE:   prdata = ftqg_pkg::PDATA_W'(cfg_q.upgrade);
			ftqg_pkg::REG_DOWN_HOLD: prdata = ftqg_pkg::PDATA_W'(cfg_q.down_hold);
			ftqg_pkg::REG_UP_HOLD:   prdata = ftqg_pkg::PDATA_W'(cfg_q.up_hold);
			default:                 prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/ftqg_dp.sv */
`timescale 1ns / 1ps

module ftqg_dp #(
	parameter int NUM_LEVELS    = 3,
	parameter int AVG_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ftqg_pkg::cfg_t                 cfg,
	input  ftqg_pkg::dp_cmd_t              cmd,
	output ftqg_pkg::dp_sts_t              sts,
	input  logic                           in_req_type,
	input  logic [ftqg_pkg::TIME_W-1:0]    in_frame_time_us,
	input  logic [ftqg_pkg::DIM_W-1:0]     in_req_width,
	input  logic [ftqg_pkg::DIM_W-1:0]     in_req_height,
	output logic [ftqg_pkg::LVL_W-1:0]     out_quality_level,
	output logic [ftqg_pkg::CHG_W-1:0]     out_level_change,
	output logic [ftqg_pkg::DIM_W-1:0]     out_width,
	output logic [ftqg_pkg::DIM_W-1:0]     out_height
);

	localparam int AVG_W  = ftqg_pkg::TIME_W + AVG_FRAC_BITS;
	localparam int PROD_W = AVG_W + ftqg_pkg::ALPHA_W;
	localparam int SUM_W  = PROD_W + 1;
	localparam int DIM_W  = ftqg_pkg::DIM_W;
	localparam int ACC_W  = ftqg_pkg::ACC_W;
	localparam logic [SUM_W-1:0] ROUND = SUM_W'((1 << ftqg_pkg::ALPHA_FRAC) - 1);

	// Captured item.
	logic                           type_q;
	logic [ftqg_pkg::TIME_W-1:0]    t_q;
	logic [DIM_W-1:0]               w_q;
	logic [DIM_W-1:0]               h_q;

	// Governor state.
	logic [AVG_W-1:0]               avg_q;
	logic                           avg_valid_q;
	logic [ACC_W-1:0]               slow_q;
	logic [ACC_W-1:0]               fast_q;
	logic [ftqg_pkg::LVL_W-1:0]     level_q;

	// Working registers.
	logic [AVG_W-1:0]               diff_q;
	logic                           dn_q;
	logic [ftqg_pkg::MUL_W-1:0]     pp_lo_q;
	logic [ftqg_pkg::MUL_W-1:0]     pp_hi_q;
	logic [AVG_W-1:0]               step_q;
	logic [ftqg_pkg::CHG_W-1:0]     change_q;
	logic [DIM_W-1:0]               ow_q;
	logic [DIM_W-1:0]               oh_q;
	logic                           sel_w_q;
	logic [DIM_W-1:0]               dvs_q;
	logic [DIM_W-1:0]               rem_q;
	logic [DIM_W-1:0]               quo_q;
	logic [ftqg_pkg::DIV_CNT_W-1:0] cnt_q;

	// Result register.
	logic [ftqg_pkg::LVL_W-1:0]     res_level_q;
	logic [ftqg_pkg::CHG_W-1:0]     res_change_q;
	logic [DIM_W-1:0]               res_w_q;
	logic [DIM_W-1:0]               res_h_q;

	logic [AVG_W-1:0]               tq;
	logic [DIM_W-1:0]               bw;
	logic [DIM_W-1:0]               bh;
	logic [ftqg_pkg::MUL_A_W-1:0]   mul_a;
	logic [ftqg_pkg::ALPHA_W-1:0]   mul_b;
	logic [ftqg_pkg::MUL_W-1:0]     mul_p;
	logic [SUM_W-1:0]               sum;
	logic [AVG_W-1:0]               bud_fx;
	logic [AVG_W-1:0]               upg_fx;
	logic [ACC_W:0]                 slow_sum;
	logic [ACC_W:0]                 fast_sum;
	logic [ACC_W-1:0]               slow_sat;
	logic [ACC_W-1:0]               fast_sat;
	logic                           sel_w;
	logic [ftqg_pkg::CAP_PROD_W-1:0] dividend;
	logic [DIM_W:0]                 rem_sh;
	logic [DIM_W:0]                 rem_sub;
	logic                           q_bit;

	assign tq     = AVG_W'(t_q) << AVG_FRAC_BITS;
	assign bw     = ftqg_pkg::box_w(level_q);
	assign bh     = ftqg_pkg::box_h(level_q);
	assign bud_fx = AVG_W'(cfg.budget) << AVG_FRAC_BITS;
	assign upg_fx = AVG_W'(cfg.upgrade) << AVG_FRAC_BITS;

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = diff_q[ftqg_pkg::MUL_A_W-1:0];
		mul_b = cfg.alpha;
		if (cmd.mul_hi) begin
			mul_a = ftqg_pkg::MUL_A_W'(diff_q >> ftqg_pkg::MUL_A_W);
		end else if (cmd.cap_ma) begin
			mul_a = ftqg_pkg::MUL_A_W'(h_q);
			mul_b = ftqg_pkg::ALPHA_W'(bw);
		end else if (cmd.cap_mb) begin
			mul_a = ftqg_pkg::MUL_A_W'(w_q);
			mul_b = ftqg_pkg::ALPHA_W'(bh);
		end
	end

	assign mul_p = ftqg_pkg::MUL_W'(mul_a) * ftqg_pkg::MUL_W'(mul_b);

	// Join the partial products; a downward step rounds up so the average
	// never undershoots the sample.
	assign sum = (SUM_W'(pp_hi_q) << ftqg_pkg::MUL_A_W) + SUM_W'(pp_lo_q)
		+ (dn_q ? ROUND : '0);

	// Saturating accumulators.
	assign slow_sum = (ACC_W + 1)'(slow_q) + (ACC_W + 1)'(t_q);
	assign fast_sum = (ACC_W + 1)'(fast_q) + (ACC_W + 1)'(t_q);
	assign slow_sat = slow_sum[ACC_W] ? ftqg_pkg::ACC_MAX : slow_sum[ACC_W-1:0];
	assign fast_sat = fast_sum[ACC_W] ? ftqg_pkg::ACC_MAX : fast_sum[ACC_W-1:0];

	// Cap side: fit width when box_w * h <= box_h * w, else fit height.
	assign sel_w    = pp_lo_q <= pp_hi_q;
	assign dividend = sel_w ? pp_lo_q[ftqg_pkg::CAP_PROD_W-1:0]
		: pp_hi_q[ftqg_pkg::CAP_PROD_W-1:0];

	// One restoring division step.
	assign rem_sh  = {rem_q, quo_q[DIM_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign q_bit   = rem_sh >= {1'b0, dvs_q};

	// Status for the controller.
	always_comb begin
		sts.is_cap    = type_q;
		sts.t_zero    = t_q == '0;
		sts.avg_valid = avg_valid_q;
		sts.cap_pass  = (level_q == '0) || (w_q == '0) || (h_q == '0)
			|| ((w_q <= bw) && (h_q <= bh));
		sts.div_last  = cnt_q == ftqg_pkg::DIV_CNT_W'(ftqg_pkg::DIV_STEPS - 1);
	end

	// Governor state: average, accumulators and level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q       <= '0;
			avg_valid_q <= 1'b0;
			slow_q      <= '0;
			fast_q      <= '0;
			level_q     <= '0;
			cnt_q       <= '0;
		end else begin
			if (cmd.seed) begin
				avg_q       <= tq;
				avg_valid_q <= 1'b1;
			end
			if (cmd.avg) begin
				avg_q <= dn_q ? avg_q - step_q : avg_q + step_q;
			end
			if (cmd.acc) begin
				if (avg_q > bud_fx) begin
					slow_q <= slow_sat;
					fast_q <= '0;
				end else if (avg_q < upg_fx) begin
					fast_q <= fast_sat;
					slow_q <= '0;
				end else begin
					slow_q <= '0;
					fast_q <= '0;
				end
			end
			if (cmd.lvl) begin
				if (slow_q >= cfg.down_hold
						&& level_q < ftqg_pkg::LVL_W'(NUM_LEVELS)) begin
					level_q <= level_q + 1'b1;
					slow_q  <= '0;
				end else if (fast_q >= cfg.up_hold && level_q != '0) begin
					level_q <= level_q - 1'b1;
					fast_q  <= '0;
				end
			end
			if (cmd.cap_sel) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Item capture and working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q   <= in_req_type;
			t_q      <= in_frame_time_us;
			w_q      <= in_req_width;
			h_q      <= in_req_height;
			change_q <= ftqg_pkg::CHG_NONE;
			ow_q     <= in_req_type ? in_req_width : '0;
			oh_q     <= in_req_type ? in_req_height : '0;
		end
		if (cmd.diff) begin
			dn_q   <= !(tq >= avg_q);
			diff_q <= (tq >= avg_q) ? tq - avg_q : avg_q - tq;
		end
		if (cmd.mul_lo || cmd.cap_ma) begin
			pp_lo_q <= mul_p;
		end
		if (cmd.mul_hi || cmd.cap_mb) begin
			pp_hi_q <= mul_p;
		end
		if (cmd.sum) begin
			step_q <= AVG_W'(sum >> ftqg_pkg::ALPHA_FRAC);
		end
		if (cmd.lvl) begin
			if (slow_q >= cfg.down_hold && level_q < ftqg_pkg::LVL_W'(NUM_LEVELS)) begin
				change_q <= ftqg_pkg::CHG_RAISED;
			end else if (fast_q >= cfg.up_hold && level_q != '0) begin
				change_q <= ftqg_pkg::CHG_LOWERED;
			end
		end
		if (cmd.cap_sel) begin
			sel_w_q <= sel_w;
			dvs_q   <= sel_w ? w_q : h_q;
			rem_q   <= DIM_W'(dividend[ftqg_pkg::CAP_PROD_W-1:DIM_W]);
			quo_q   <= dividend[DIM_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= q_bit ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
			quo_q <= {quo_q[DIM_W-2:0], q_bit};
		end
		if (cmd.cap_fix) begin
			if (sel_w_q) begin
				ow_q <= bw;
				oh_q <= (quo_q < ftqg_pkg::MIN_H) ? ftqg_pkg::MIN_H : quo_q;
			end else begin
				oh_q <= bh;
				ow_q <= (quo_q < ftqg_pkg::MIN_W) ? ftqg_pkg::MIN_W : quo_q;
			end
		end
		if (cmd.finish) begin
			res_level_q  <= level_q;
			res_change_q <= change_q;
			res_w_q      <= ow_q;
			res_h_q      <= oh_q;
		end
	end

	assign out_quality_level = res_level_q;
	assign out_level_change  = res_change_q;
	assign out_width         = res_w_q;
	assign out_height        = res_h_q;

endmodule

/* hw/rtl/ftqg_ctrl.sv */
`timescale 1ns / 1ps

module ftqg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ftqg_pkg::dp_sts_t    sts,
	output ftqg_pkg::dp_cmd_t    cmd
);

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_DECODE = 16'h0002,
		S_SEED   = 16'h0004,
		S_DIFF   = 16'h0008,
		S_MLO    = 16'h0010,
		S_MHI    = 16'h0020,
		S_SUM    = 16'h0040,
		S_AVG    = 16'h0080,
		S_ACC    = 16'h0100,
		S_LVL    = 16'h0200,
		S_CMA    = 16'h0400,
		S_CMB    = 16'h0800,
		S_CSEL   = 16'h1000,
		S_DIV    = 16'h2000,
		S_CFIX   = 16'h4000,
		S_FINISH = 16'h8000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   res_free;

	// The result register can take a new beat when empty or being drained.
	assign res_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:   if (in_valid) state_nxt = S_DECODE;
			S_DECODE: begin
				if (sts.is_cap) begin
					state_nxt = sts.cap_pass ? S_FINISH : S_CMA;
				end else if (sts.t_zero) begin
					state_nxt = S_FINISH;
				end else begin
					state_nxt = sts.avg_valid ? S_DIFF : S_SEED;
				end
			end
			S_SEED:   state_nxt = S_FINISH;
			S_DIFF:   state_nxt = S_MLO;
			S_MLO:    state_nxt = S_MHI;
			S_MHI:    state_nxt = S_SUM;
			S_SUM:    state_nxt = S_AVG;
			S_AVG:    state_nxt = S_ACC;
			S_ACC:    state_nxt = S_LVL;
			S_LVL:    state_nxt = S_FINISH;
			S_CMA:    state_nxt = S_CMB;
			S_CMB:    state_nxt = S_CSEL;
			S_CSEL:   state_nxt = S_DIV;
			S_DIV:    if (sts.div_last) state_nxt = S_CFIX;
			S_CFIX:   state_nxt = S_FINISH;
			S_FINISH: if (res_free) state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == S_IDLE) && in_valid;
		cmd.seed     = state_q == S_SEED;
		cmd.diff     = state_q == S_DIFF;
		cmd.mul_lo   = state_q == S_MLO;
		cmd.mul_hi   = state_q == S_MHI;
		cmd.sum      = state_q == S_SUM;
		cmd.avg      = state_q == S_AVG;
		cmd.acc      = state_q == S_ACC;
		cmd.lvl      = state_q == S_LVL;
		cmd.cap_ma   = state_q == S_CMA;
		cmd.cap_mb   = state_q == S_CMB;
		cmd.cap_sel  = state_q == S_CSEL;
		cmd.div_step = state_q == S_DIV;
		cmd.cap_fix  = state_q == S_CFIX;
		cmd.finish   = (state_q == S_FINISH) && res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/frame_time_quality_governor_top.sv */
// A pass-through item goes from decode straight to finish, which registers the result beat.
// A frame report that updates the average passes diff, multiply low and high, sum, average,
// accumulate and level; a cap request, both cap multiplies, side select, the 14-step serial
// divider and fix-up. A waiting result beat lets the next item in but holds it at finish.
// Reset (arst_n low) clears the average, both accumulators and the level, empties the result
// register and loads the configuration registers with their default values.
`timescale 1ns / 1ps

module frame_time_quality_governor_top #(
	parameter int NUM_LEVELS    = 3,
	parameter int AVG_FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ftqg_req_if.sink                       req,
	ftqg_res_if.source                     res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ftqg_pkg::PADDR_W-1:0]   paddr,
	input  logic [ftqg_pkg::PDATA_W-1:0]   pwdata,
	output logic [ftqg_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	ftqg_pkg::cfg_t     cfg;
	ftqg_pkg::dp_cmd_t  cmd;
	ftqg_pkg::dp_sts_t  sts;
	logic               in_ready;
	logic               out_valid;

	assign req.ready = in_ready;
	assign res.valid = out_valid;

	// Configuration registers.
	ftqg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer.
	ftqg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Average, accumulators, level and cap arithmetic.
	ftqg_dp #(
		.NUM_LEVELS    (NUM_LEVELS),
		.AVG_FRAC_BITS (AVG_FRAC_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.sts               (sts),
		.in_req_type       (req.req_type),
		.in_frame_time_us  (req.frame_time_us),
		.in_req_width      (req.req_width),
		.in_req_height     (req.req_height),
		.out_quality_level (res.quality_level),
		.out_level_change  (res.level_change),
		.out_width         (res.out_width),
		.out_height        (res.out_height)
	);

endmodule

/* tb/frame_time_quality_governor_top_tb.sv */
`timescale 1ns / 1ps

module frame_time_quality_governor_top_tb;
	import ftqg_pkg::*;

	localparam int GOV_LEVELS = 3;
	localparam int FRAC       = 16;
	localparam int TIME_MAX   = 1000000;
	localparam int DIM_MAX    = 16383;
	localparam int HOLD_MAX   = 67108863;
	localparam int IDLE_LIMIT = 2000;
	localparam int SQUEEZE    = 400;
	localparam int SETTLE     = 40;

	localparam logic REQ_FRAME = 1'b0;
	localparam logic REQ_CAP   = 1'b1;

	typedef enum int {RG_SLOW, RG_FAST, RG_MID, RG_HEAVY, RG_WILD} regime_t;

	typedef struct packed {
		logic              req_type;
		logic [TIME_W-1:0] frame_time_us;
		logic [DIM_W-1:0]  req_width;
		logic [DIM_W-1:0]  req_height;
	} gov_req_t;

	typedef struct packed {
		logic [LVL_W-1:0] quality_level;
		chg_t             level_change;
		logic [DIM_W-1:0] out_width;
		logic [DIM_W-1:0] out_height;
	} gov_res_t;

	// Governor state mirror, expected result beats and the error count.
	class gov_scoreboard;
		logic [ALPHA_W-1:0] alpha     = RST_ALPHA;
		logic [TIME_W-1:0]  budget    = RST_BUDGET;
		logic [TIME_W-1:0]  upgrade   = RST_UPGRADE;
		logic [ACC_W-1:0]   down_hold = RST_DOWN_HOLD;
		logic [ACC_W-1:0]   up_hold   = RST_UP_HOLD;
		logic [63:0]        avg_q16   = '0;
		bit                 avg_seen  = 1'b0;
		logic [ACC_W-1:0]   slow_us   = '0;
		logic [ACC_W-1:0]   fast_us   = '0;
		logic [LVL_W-1:0]   level     = '0;
		gov_res_t           expected_results[$];
		int                 failures  = 0;

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
			case (idx)
				REG_ALPHA:     alpha = val[ALPHA_W-1:0];
				REG_BUDGET:    budget = val[TIME_W-1:0];
				REG_UPGRADE:   upgrade = val[TIME_W-1:0];
				REG_DOWN_HOLD: down_hold = val[ACC_W-1:0];
				REG_UP_HOLD:   up_hold = val[ACC_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [ACC_W-1:0] add_sat(logic [ACC_W-1:0] a, logic [TIME_W-1:0] b);
			logic [ACC_W:0] s;
			s = a + b;
			return (s > ACC_MAX) ? ACC_MAX : s[ACC_W-1:0];
		endfunction

		// Moves the frame time average and the accumulators, then the level.
		function chg_t track_frame_time(logic [TIME_W-1:0] t);
			logic [63:0] tq;
			if (t == 0)
				return CHG_NONE;
			tq = 64'(t) << FRAC;
			if (!avg_seen) begin
				avg_q16 = tq;
				avg_seen = 1'b1;
				return CHG_NONE;
			end
			if (tq >= avg_q16)
				avg_q16 = avg_q16 + (((tq - avg_q16) * 64'(alpha)) >> ALPHA_FRAC);
			else
				avg_q16 = avg_q16 - ((((avg_q16 - tq) * 64'(alpha)) + 64'hFFFF) >> ALPHA_FRAC);
			if (avg_q16 > (64'(budget) << FRAC)) begin
				slow_us = add_sat(slow_us, t);
				fast_us = '0;
			end else if (avg_q16 < (64'(upgrade) << FRAC)) begin
				fast_us = add_sat(fast_us, t);
				slow_us = '0;
			end else begin
				slow_us = '0;
				fast_us = '0;
			end
			if (slow_us >= down_hold && level < GOV_LEVELS) begin
				level = level + 1'b1;
				slow_us = '0;
				return CHG_RAISED;
			end
			if (fast_us >= up_hold && level > 0) begin
				level = level - 1'b1;
				fast_us = '0;
				return CHG_LOWERED;
			end
			return CHG_NONE;
		endfunction

		// Fits a size into the box of the current level, keeping the aspect ratio.
		function void cap_resolution(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
			output logic [DIM_W-1:0] ow, output logic [DIM_W-1:0] oh);
			logic [31:0] bw, bh, nw, nh;
			ow = w;
			oh = h;
			if (level == 0 || w == 0 || h == 0)
				return;
			case (level)
				2'd1: begin
					bw = 1280;
					bh = 720;
				end
				2'd2: begin
					bw = 960;
					bh = 540;
				end
				default: begin
					bw = 640;
					bh = 360;
				end
			endcase
			if (w <= bw && h <= bh)
				return;
			if (bw * 32'(h) <= bh * 32'(w)) begin
				nw = bw;
				nh = (32'(h) * bw) / 32'(w);
			end else begin
				nh = bh;
				nw = (32'(w) * bh) / 32'(h);
			end
			if (nw < 160)
				nw = 160;
			if (nh < 90)
				nh = 90;
			ow = nw[DIM_W-1:0];
			oh = nh[DIM_W-1:0];
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= 10)
				$display("%s", msg);
		endfunction

		function void note_request(gov_req_t r);
			gov_res_t e;
			e = '0;
			e.level_change = CHG_NONE;
			if (r.req_type == REQ_FRAME)
				e.level_change = track_frame_time(r.frame_time_us);
			else
				cap_resolution(r.req_width, r.req_height, e.out_width, e.out_height);
			e.quality_level = level;
			expected_results.push_back(e);
		endfunction

		function void check_result(gov_res_t got);
			gov_res_t e;
			if (expected_results.size() == 0) begin
				flag($sformatf("unexpected result beat: level %0d change %0d size %0dx%0d",
					got.quality_level, got.level_change, got.out_width, got.out_height));
				return;
			end
			e = expected_results.pop_front();
			if (got.quality_level !== e.quality_level || got.level_change !== e.level_change
				|| got.out_width !== e.out_width || got.out_height !== e.out_height)
				flag($sformatf({"result mismatch: expected level %0d change %0d size %0dx%0d,",
					" got level %0d change %0d size %0dx%0d"},
					e.quality_level, e.level_change, e.out_width, e.out_height,
					got.quality_level, got.level_change, got.out_width, got.out_height));
		endfunction

		function void close_out();
			if (expected_results.size() != 0)
				flag($sformatf("%0d result beats never arrived", expected_results.size()));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	ftqg_req_if req_if ();
	ftqg_res_if res_if ();

	gov_scoreboard sb = new();

	bit tx_quiet;
	bit rx_quiet;
	bit rx_hold_req;
	bit rx_hold;
	int rx_wait;
	int idle_cycles;

	frame_time_quality_governor_top #(
		.NUM_LEVELS    (GOV_LEVELS),
		.AVG_FRAC_BITS (FRAC)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.res     (res_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random stalls per beat, then the beat goes to the scoreboard.
	initial begin
		gov_res_t got;
		res_if.ready = 1'b0;
		rx_wait = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold || rx_wait > 0) begin
				res_if.ready <= 1'b0;
				if (!rx_hold)
					rx_wait--;
			end else begin
				res_if.ready <= 1'b1;
			end
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				got.quality_level = res_if.quality_level;
				got.level_change = chg_t'(res_if.level_change);
				got.out_width = res_if.out_width;
				got.out_height = res_if.out_height;
				sb.check_result(got);
				rx_wait = rx_quiet ? 0 : $urandom_range(0, 11);
			end
		end
	end

	// Long hold-off on the result side so that the block backs up into its input.
	initial begin
		rx_hold = 1'b0;
		wait (rx_hold_req);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (SQUEEZE) @(posedge clk);
		rx_hold = 1'b0;
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Sends one request beat; entered and left at a falling edge.
	task automatic send_req(gov_req_t it);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		{req_if.req_type, req_if.frame_time_us, req_if.req_width, req_if.req_height} <= it;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(it);
		@(negedge clk);
	endtask

	// One register write, after which the bus returns to idle; entered and left at a falling edge.
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic write_config(int a, int b, int u, int dh, int uh);
		write_reg(REG_ALPHA, a);
		write_reg(REG_BUDGET, b);
		write_reg(REG_UPGRADE, u);
		write_reg(REG_DOWN_HOLD, dh);
		write_reg(REG_UP_HOLD, uh);
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		do @(negedge clk); while (sb.expected_results.size() != 0);
	endtask

	function automatic gov_req_t mk_frame(int t);
		gov_req_t it;
		it = '0;
		it.req_type = REQ_FRAME;
		it.frame_time_us = t;
		return it;
	endfunction

	function automatic gov_req_t mk_cap(int w, int h);
		gov_req_t it;
		it = '0;
		it.req_type = REQ_CAP;
		it.req_width = w;
		it.req_height = h;
		return it;
	endfunction

	// Frame times follow a regime picked around the current thresholds.
	function automatic gov_req_t frame_item(regime_t regime);
		gov_req_t it;
		int b, u, lo, hi;
		b = sb.budget;
		u = sb.upgrade;
		case (regime)
			RG_SLOW: begin
				lo = b + 1;
				hi = b + b / 2 + 2000;
			end
			RG_FAST: begin
				lo = 1;
				hi = (u > 1) ? u - 1 : 1000;
			end
			RG_MID: begin
				lo = (u < b) ? u : b;
				hi = (u < b) ? b : u;
			end
			RG_HEAVY: begin
				lo = 500000;
				hi = TIME_MAX;
			end
			default: begin
				lo = 0;
				hi = TIME_MAX;
			end
		endcase
		if (hi > TIME_MAX)
			hi = TIME_MAX;
		if (lo > hi)
			lo = hi;
		it.req_type = REQ_FRAME;
		it.frame_time_us = $urandom_range(hi, lo);
		it.req_width = $urandom;
		it.req_height = $urandom;
		if ($urandom_range(0, 29) == 0)
			it.frame_time_us = '0;
		return it;
	endfunction

	function automatic gov_req_t cap_item();
		gov_req_t it;
		it.req_type = REQ_CAP;
		it.frame_time_us = $urandom_range(0, TIME_MAX);
		case ($urandom_range(0, 7))
			0: begin
				it.req_width = $urandom_range(0, DIM_MAX);
				it.req_height = '0;
				if ($urandom_range(0, 1))
					{it.req_width, it.req_height} = {it.req_height, it.req_width};
			end
			1: begin
				it.req_width = $urandom_range(0, 1) ? DIM_MAX : 1;
				it.req_height = $urandom_range(0, 1) ? DIM_MAX : 1;
			end
			2, 3: begin
				it.req_width = $urandom_range(1, 1500);
				it.req_height = $urandom_range(1, 900);
			end
			default: begin
				it.req_width = $urandom;
				it.req_height = $urandom;
			end
		endcase
		return it;
	endfunction

	task automatic random_items(int count);
		regime_t regime;
		regime = regime_t'($urandom_range(0, 4));
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 39) == 0)
				tx_quiet = !tx_quiet;
			if ($urandom_range(0, 39) == 0)
				rx_quiet = !rx_quiet;
			if ($urandom_range(0, 14) == 0)
				regime = regime_t'($urandom_range(0, 4));
			if ($urandom_range(0, 99) < 25)
				send_req(cap_item());
			else
				send_req(frame_item(regime));
		end
	endtask

	task automatic run_phase(int a, int b, int u, int dh, int uh, int count, bit squeeze);
		write_config(a, b, u, dh, uh);
		tx_quiet = $urandom_range(0, 1);
		rx_quiet = $urandom_range(0, 1);
		if (squeeze)
			rx_hold_req = 1'b1;
		random_items(count);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.req_type = REQ_FRAME;
		req_if.frame_time_us = '0;
		req_if.req_width = '0;
		req_if.req_height = '0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		rx_hold_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: pass-through at level zero, ignored zero time, seeding.
		send_req(mk_cap(1920, 1080));
		send_req(mk_cap(0, 5));
		send_req(mk_frame(0));
		send_req(mk_frame(16000));
		send_req(mk_frame(0));
		send_req(mk_frame(TIME_MAX));
		send_req(mk_cap(DIM_MAX, DIM_MAX));
		wait_drained();

		// Zero hold times: the level climbs to its top, every box is used, then it drops.
		write_config(65535, 20000, 14000, 0, 0);
		send_req(mk_frame(TIME_MAX));
		send_req(mk_cap(1920, 1080));
		send_req(mk_frame(TIME_MAX));
		send_req(mk_cap(1920, 1200));
		send_req(mk_frame(TIME_MAX));
		send_req(mk_frame(TIME_MAX));
		send_req(mk_cap(DIM_MAX, DIM_MAX));
		send_req(mk_cap(DIM_MAX, 1));
		send_req(mk_cap(1, DIM_MAX));
		send_req(mk_cap(640, 360));
		send_req(mk_cap(641, 360));
		send_req(mk_cap(100, 0));
		send_req(mk_frame(17000));
		send_req(mk_frame(1));
		send_req(mk_frame(1));
		send_req(mk_frame(1));
		send_req(mk_cap(DIM_MAX, DIM_MAX));
		wait_drained();

		// Random phases over several settings, the register extremes among them.
		run_phase(3277, 20000, 14000, 150000, 300000, 220, 1'b1);
		run_phase(65535, TIME_MAX, 0, 0, 0, 120, 1'b0);
		run_phase(1, 0, TIME_MAX, HOLD_MAX, HOLD_MAX, 300, 1'b0);
		run_phase(40000, 500000, 300000, 2000000, 3000000, 200, 1'b0);
		run_phase(20000, 30000, 25000, 50000, 80000, 200, 1'b0);

		repeat (SETTLE) @(negedge clk);
		sb.close_out();
		if (sb.failures == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
